### rtl/pipe_byte_fifo_with_endpoints_core_defines.svh
`ifndef PIPE_BYTE_FIFO_WITH_ENDPOINTS_CORE_DEFINES_SVH
`define PIPE_BYTE_FIFO_WITH_ENDPOINTS_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PBF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pbf_pkg.sv
`default_nettype none

package pbf_pkg;

	localparam int DATA_W   = 8;
	localparam int LEN_W    = 16;
	localparam int FILL_W   = 13;
	localparam int STATUS_W = 3;

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_READ   = 2'd1,
		ACT_ATTACH = 2'd2,
		ACT_DETACH = 2'd3
	} action_t;

	localparam logic [1:0] MODE_RD  = 2'd0;
	localparam logic [1:0] MODE_WR  = 2'd1;
	localparam logic [1:0] MODE_RW  = 2'd2;
	localparam logic [1:0] MODE_BAD = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_EOF         = 3'd1,
		ST_WOULD_BLOCK = 3'd2,
		ST_MUST_WAIT   = 3'd3,
		ST_BROKEN      = 3'd4,
		ST_BAD_END     = 3'd5,
		ST_SHORT       = 3'd6
	} status_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

### rtl/pbf_ring_mem.sv
`default_nettype none

module pbf_ring_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic                      clk,
	input  wire pbf_pkg::mem_ctl_t         ctl,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [pbf_pkg::DATA_W-1:0] wdata,
	input  wire logic [AW-1:0]             raddr,
	output logic      [pbf_pkg::DATA_W-1:0] rdata
);
	import pbf_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/pbf_ctrl.sv
`default_nettype none

module pbf_ctrl #(
	parameter int CAPACITY   = 4096,
	parameter int COUNT_BITS = 16,
	parameter int AW         = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [1:0]                    action,
	input  wire logic                          first_of_request,
	input  wire logic [pbf_pkg::LEN_W-1:0]     request_length,
	input  wire logic [1:0]                    access_mode,
	input  wire logic                          nonblock,
	input  wire logic [1:0]                    poll_events,
	output pbf_pkg::mem_ctl_t                  mem_ctl,
	output logic      [AW-1:0]                 waddr,
	output logic      [AW-1:0]                 raddr,
	output logic                               done,
	output logic                               got,
	output logic      [pbf_pkg::STATUS_W-1:0]  status,
	output logic                               readable,
	output logic                               writable,
	output logic                               hang_up,
	output logic                               pipe_error,
	output logic      [pbf_pkg::FILL_W-1:0]    fill_level
);
	import pbf_pkg::*;

	`include "pipe_byte_fifo_with_endpoints_core_defines.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > LEN_W + 1) ? CNT_W : LEN_W + 1;
	localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
	localparam logic [CMP_W-1:0] CAP_CMP  = CMP_W'(CAPACITY);
	localparam logic [AW-1:0]    PTR_LAST = AW'(CAPACITY - 1);

	logic [AW-1:0]         wp_q, rp_q, wp_nxt, rp_nxt;
	logic [CNT_W-1:0]      cnt_q, cnt_nxt;
	logic [COUNT_BITS-1:0] rd_cnt_q, wr_cnt_q, rd_nxt, wr_nxt;
	logic                  drop_q, drop_nxt;
	logic                  push, pop, clear;
	status_t               st, st_wait;
	action_t               act;
	logic                  may_read, may_write, mode_bad, full, empty, fits;
	logic [CMP_W-1:0]      space, len_cmp;

	logic                  done_q, got_q;
	status_t               status_q;
	logic                  readable_q, writable_q, hang_up_q, pipe_error_q;
	logic [FILL_W-1:0]     fill_q;

	assign act       = action_t'(action);
	assign mode_bad  = (access_mode == MODE_BAD);
	assign may_read  = (access_mode == MODE_RD) || (access_mode == MODE_RW);
	assign may_write = (access_mode == MODE_WR) || (access_mode == MODE_RW);
	assign full      = (cnt_q == CAP_CNT);
	assign empty     = (cnt_q == '0);
	assign space     = CMP_W'(CAP_CNT - cnt_q);
	assign len_cmp   = CMP_W'(request_length);
	assign fits      = !(len_cmp <= CAP_CMP && space < len_cmp);
	assign st_wait   = nonblock ? ST_WOULD_BLOCK : ST_MUST_WAIT;

	always_comb begin
		push     = 1'b0;
		pop      = 1'b0;
		clear    = 1'b0;
		st       = ST_OK;
		drop_nxt = drop_q;
		rd_nxt   = rd_cnt_q;
		wr_nxt   = wr_cnt_q;
		if (accept) begin
			case (act)
				ACT_WRITE, ACT_READ: begin
					if (!first_of_request && drop_q) begin
						st = ST_SHORT;
					end else if ((act == ACT_WRITE) ? !may_write : !may_read) begin
						st       = ST_BAD_END;
						drop_nxt = 1'b1;
					end else begin
						drop_nxt = 1'b0;
						if (act == ACT_WRITE) begin
							if (first_of_request) begin
								if (request_length == '0) begin
									drop_nxt = 1'b1;
								end else if (rd_cnt_q == '0) begin
									st       = ST_BROKEN;
									drop_nxt = 1'b1;
								end else if (!fits || full) begin
									st       = st_wait;
									drop_nxt = 1'b1;
								end else begin
									push = 1'b1;
								end
							end else if (full) begin
								st       = ST_SHORT;
								drop_nxt = 1'b1;
							end else begin
								push = 1'b1;
							end
						end else begin
							if (first_of_request) begin
								if (request_length == '0) begin
									drop_nxt = 1'b1;
								end else if (empty) begin
									st       = (wr_cnt_q == '0) ? ST_EOF : st_wait;
									drop_nxt = 1'b1;
								end else begin
									pop = 1'b1;
								end
							end else if (empty) begin
								st       = ST_SHORT;
								drop_nxt = 1'b1;
							end else begin
								pop = 1'b1;
							end
						end
					end
				end
				ACT_ATTACH: begin
					if (mode_bad) begin
						st = ST_BAD_END;
					end else begin
						if (may_write && wr_cnt_q != '1) wr_nxt = wr_cnt_q + 1'b1;
						if (may_read && rd_cnt_q != '1) rd_nxt = rd_cnt_q + 1'b1;
					end
				end
				ACT_DETACH: begin
					if (mode_bad) begin
						st = ST_BAD_END;
					end else begin
						if (may_write && wr_cnt_q != '0) wr_nxt = wr_cnt_q - 1'b1;
						if (may_read && rd_cnt_q != '0) rd_nxt = rd_cnt_q - 1'b1;
						clear = (rd_nxt == '0) && (wr_nxt == '0);
					end
				end
				default: begin
					st = ST_OK;
				end
			endcase
		end
	end

	always_comb begin
		wp_nxt  = wp_q;
		rp_nxt  = rp_q;
		cnt_nxt = cnt_q;
		if (clear) begin
			wp_nxt  = '0;
			rp_nxt  = '0;
			cnt_nxt = '0;
		end else if (push) begin
			wp_nxt  = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
			cnt_nxt = cnt_q + 1'b1;
		end else if (pop) begin
			rp_nxt  = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
			cnt_nxt = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
			drop_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			wp_q     <= wp_nxt;
			rp_q     <= rp_nxt;
			cnt_q    <= cnt_nxt;
			rd_cnt_q <= rd_nxt;
			wr_cnt_q <= wr_nxt;
			drop_q   <= drop_nxt;
			done_q   <= accept;
		end
	end

	// hold the result of the last transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			got_q        <= pop;
			status_q     <= st;
			readable_q   <= may_read && (cnt_nxt != '0) && poll_events[0];
			writable_q   <= may_write && (rd_nxt != '0) && (cnt_nxt != CAP_CNT)
				&& poll_events[1];
			hang_up_q    <= may_read && (wr_nxt == '0);
			pipe_error_q <= may_write && (rd_nxt == '0);
			fill_q       <= FILL_W'(cnt_nxt);
		end
	end

	assign mem_ctl.wr_en = push;
	assign mem_ctl.rd_en = pop;
	assign waddr         = wp_q;
	assign raddr         = rp_q;
	assign done          = done_q;
	assign got           = got_q;
	assign status        = status_q;
	assign readable      = readable_q;
	assign writable      = writable_q;
	assign hang_up       = hang_up_q;
	assign pipe_error    = pipe_error_q;
	assign fill_level    = fill_q;

	`PBF_ASSERT_NOW(a_pop_not_empty, pop, cnt_q != '0, "pop from empty ring")
	`PBF_ASSERT_NOW(a_push_not_full, push, cnt_q != CAP_CNT, "push into full ring")
	`PBF_ASSERT_NEXT(a_done_follows, accept, done, "no result after transfer")
	`PBF_ASSERT_NEXT(a_clear_empties, clear, cnt_q == '0 && wp_q == '0 && rp_q == '0,
		"ring not emptied on last detach")

endmodule

`default_nettype wire

### rtl/pipe_byte_fifo_with_endpoints_core.sv
// Byte pipe with endpoint counts. An item is taken on every cycle in which start is
// high; busy is never raised, so one item per cycle is sustained. Its result appears
// one cycle after acceptance for exactly one cycle, marked by done, and must be
// captured then: the receiver cannot stall. The read byte is held by the registered
// read port of the byte ring memory, status and flags by controller registers; ring
// pointers, fill count and endpoint counts are registers updated in the accepting
// cycle. The ring needs no clearing pass, so the block is ready right out of reset.
`default_nettype none

module pipe_byte_fifo_with_endpoints_core #(
	parameter int CAPACITY   = 4096,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    action,
	input  wire logic [pbf_pkg::DATA_W-1:0]    data_byte,
	input  wire logic                          first_of_request,
	input  wire logic [pbf_pkg::LEN_W-1:0]     request_length,
	input  wire logic [1:0]                    access_mode,
	input  wire logic                          nonblock,
	input  wire logic [1:0]                    poll_events,
	output logic                               done,
	output logic      [pbf_pkg::DATA_W-1:0]    read_byte,
	output logic      [pbf_pkg::STATUS_W-1:0]  status,
	output logic                               readable,
	output logic                               writable,
	output logic                               hang_up,
	output logic                               pipe_error,
	output logic      [pbf_pkg::FILL_W-1:0]    fill_level
);
	import pbf_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	mem_ctl_t          mem_ctl;
	logic [AW-1:0]     waddr, raddr;
	logic [DATA_W-1:0] rdata;
	logic              accept, got;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	pbf_ctrl #(
		.CAPACITY   (CAPACITY),
		.COUNT_BITS (COUNT_BITS),
		.AW         (AW)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.action           (action),
		.first_of_request (first_of_request),
		.request_length   (request_length),
		.access_mode      (access_mode),
		.nonblock         (nonblock),
		.poll_events      (poll_events),
		.mem_ctl          (mem_ctl),
		.waddr            (waddr),
		.raddr            (raddr),
		.done             (done),
		.got              (got),
		.status           (status),
		.readable         (readable),
		.writable         (writable),
		.hang_up          (hang_up),
		.pipe_error       (pipe_error),
		.fill_level       (fill_level)
	);

	pbf_ring_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (data_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	// drop stale ring data unless the transfer popped a byte
	assign read_byte = got ? rdata : '0;

endmodule

`default_nettype wire
